// ===== src/mtf_pkg.sv =====
// Shared constants and types for the move-to-front list.
package mtf_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_ACCESS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_MOVED     = 3'd1,
        ST_AT_FRONT  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic load_prev;
        logic load_value;
    } cell_ctrl_t;

endpackage

// ===== src/mtf_req_if.sv =====
// Request channel: mode and value with valid/ready.
interface mtf_req_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic signed [mtf_pkg::VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== src/mtf_rsp_if.sv =====
// Response channel: status, hit position and entry count with valid/ready.
interface mtf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mtf_pkg::STATUS_W-1:0] status;
    logic [mtf_pkg::POS_W-1:0]    hit_position;
    logic [mtf_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output hit_position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input hit_position, input entry_count,
                    output ready);
endinterface

// ===== src/move_to_front_list.sv =====
// Move-to-front list top level: row of cells, count register and result register.
// A request is accepted in S_IDLE or as S_UPD completes; its compare is then registered in every cell
//   (S_CMP), and S_UPD resolves the first hit along the cell chain, shifts entries and loads the
//   response into the output register; S_UPD waits while an earlier response is not yet taken.
// A waiting response does not block the next request's compare cycle.
// Reset (rst_n low, asynchronous): list empty, no response pending; entries keep garbage.
module move_to_front_list (
    input  logic        clk,
    input  logic        rst_n,
    mtf_req_if.sink     req,
    mtf_rsp_if.source   rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [mtf_pkg::CNT_W-1:0]           count_reg;
    logic [mtf_pkg::CNT_W-1:0]           count_next;
    logic                                mode_reg;
    logic [mtf_pkg::VALUE_W-1:0]         value_reg;
    logic                                rsp_valid_reg;
    logic                                rsp_valid_next;
    logic [mtf_pkg::STATUS_W-1:0]        status_reg;
    logic [mtf_pkg::STATUS_W-1:0]        status_next;
    logic [mtf_pkg::POS_W-1:0]           pos_reg;
    logic [mtf_pkg::POS_W-1:0]           pos_next;
    logic [mtf_pkg::COUNT_W-1:0]         ecount_reg;

    logic                                slot_free;
    logic                                upd_fire;
    logic                                req_fire;
    logic                                append_ok;
    logic                                do_move;
    logic [mtf_pkg::IDX_W-1:0]           hit_idx;

    logic [mtf_pkg::VALUE_W-1:0]         entry_c [mtf_pkg::DEPTH];
    logic [mtf_pkg::DEPTH:0]             hit_c;
    logic [mtf_pkg::DEPTH-1:0]           first_c;
    mtf_pkg::cell_ctrl_t                 ctrl_c  [mtf_pkg::DEPTH];

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign upd_fire  = (state_reg == S_UPD) && slot_free;
    assign req.ready = (state_reg == S_IDLE) || upd_fire;
    assign req_fire  = req.valid && req.ready;

    assign append_ok = (mode_reg == mtf_pkg::MODE_APPEND) &&
                       (count_reg != mtf_pkg::CNT_W'(mtf_pkg::DEPTH));
    assign do_move   = (mode_reg == mtf_pkg::MODE_ACCESS) && hit_c[mtf_pkg::DEPTH] &&
                       !first_c[0];

    assign hit_c[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < mtf_pkg::DEPTH; gi++)
        begin : g_cell
            logic [mtf_pkg::VALUE_W-1:0] prev;
            if (gi == 0)
            begin : g_head
                assign prev = value_reg;
            end
            else
            begin : g_body
                assign prev = entry_c[gi-1];
            end

            always_comb
            begin
                ctrl_c[gi].load_value = upd_fire &&
                    ((append_ok && (count_reg == mtf_pkg::CNT_W'(gi))) ||
                     (do_move && (gi == 0)));
                ctrl_c[gi].load_prev  = upd_fire && do_move && (gi != 0) && !hit_c[gi];
            end

            mtf_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl_c[gi]),
                .occupied   (count_reg > mtf_pkg::CNT_W'(gi)),
                .value      (value_reg),
                .prev_entry (prev),
                .hit_in     (hit_c[gi]),
                .entry      (entry_c[gi]),
                .hit_out    (hit_c[gi+1]),
                .first      (first_c[gi])
            );
        end
    endgenerate

    // First hit is one-hot, so an OR of indices encodes it.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < mtf_pkg::DEPTH; i++)
        begin
            if (first_c[i])
            begin
                hit_idx = hit_idx | mtf_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        pos_next       = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (slot_free)
                begin
                    state_next     = req_fire ? S_CMP : S_IDLE;
                    rsp_valid_next = 1'b1;
                    pos_next       = '0;
                    if (mode_reg == mtf_pkg::MODE_APPEND)
                    begin
                        if (append_ok)
                        begin
                            status_next = mtf_pkg::ST_APPENDED;
                            count_next  = count_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = mtf_pkg::ST_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = mtf_pkg::ST_EMPTY;
                    end
                    else if (!hit_c[mtf_pkg::DEPTH])
                    begin
                        status_next = mtf_pkg::ST_NOT_FOUND;
                    end
                    else if (first_c[0])
                    begin
                        status_next = mtf_pkg::ST_AT_FRONT;
                    end
                    else
                    begin
                        status_next = mtf_pkg::ST_MOVED;
                        pos_next    = mtf_pkg::POS_W'(hit_idx);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= mtf_pkg::ST_APPENDED;
            pos_reg       <= '0;
            ecount_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (upd_fire)
            begin
                status_reg <= status_next;
                pos_reg    <= pos_next;
                ecount_reg <= mtf_pkg::COUNT_W'(count_next);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg  <= req.mode;
            value_reg <= req.value;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.hit_position = pos_reg;
    assign rsp.entry_count  = ecount_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mtf_pkg::CNT_W'(mtf_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> $onehot0(first_c))
        else $error("more than one first hit");

    a_no_accept_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> !req.ready)
        else $error("request accepted during compare");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && append_ok) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not grow the list");

    a_moved_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == mtf_pkg::ST_MOVED)) |-> (rsp.hit_position != '0))
        else $error("move to front reported at position zero");

endmodule

// ===== src/mtf_cell.sv =====
// One list position: holds an entry, registers its compare and passes the hit flag on.
module mtf_cell (
    input  logic                         clk,
    input  mtf_pkg::cell_ctrl_t          ctrl,
    input  logic                         occupied,
    input  logic [mtf_pkg::VALUE_W-1:0]  value,
    input  logic [mtf_pkg::VALUE_W-1:0]  prev_entry,
    input  logic                         hit_in,
    output logic [mtf_pkg::VALUE_W-1:0]  entry,
    output logic                         hit_out,
    output logic                         first
);

    logic [mtf_pkg::VALUE_W-1:0] entry_reg;
    logic [mtf_pkg::VALUE_W-1:0] entry_next;
    logic                        match_reg;
    logic                        match_next;

    always_comb
    begin
        match_next = occupied && (entry_reg == value);
        if (ctrl.load_value)
        begin
            entry_next = value;
        end
        else if (ctrl.load_prev)
        begin
            entry_next = prev_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry   = entry_reg;
    assign first   = match_reg && !hit_in;
    assign hit_out = hit_in || match_reg;

endmodule

// ===== test/move_to_front_list_tb.sv =====
// Self-checking testbench for the move-to-front list: directed and random requests.
module move_to_front_list_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1785;
    localparam int STALL_MAX  = 2000;
    localparam int POOL_SIZE  = 10;
    localparam int DRAIN_WAIT = 10;

    typedef struct {
        logic                               mode;
        logic signed [mtf_pkg::VALUE_W-1:0] value;
        bit                                 hold;
    } mtf_req_t;

    typedef struct packed {
        mtf_pkg::status_t              status;
        logic [mtf_pkg::POS_W-1:0]     pos;
        logic [mtf_pkg::COUNT_W-1:0]   count;
    } mtf_rsp_t;

    logic clk;
    logic rst_n;

    mtf_req_if req_ch ();
    mtf_rsp_if rsp_ch ();

    move_to_front_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the list contents
    logic signed [mtf_pkg::VALUE_W-1:0] list_vals [mtf_pkg::DEPTH];
    int                                 list_len;

    mtf_req_t pending_q [$];
    mtf_rsp_t outcome_q [$];
    mtf_req_t cur_req;

    logic signed [mtf_pkg::VALUE_W-1:0] val_pool [POOL_SIZE];

    int total_items;
    int req_taken;
    int rsp_seen;
    int err_cnt;
    int stall_cycles;
    int phase;

    // Idle percentages per phase: sender, then receiver
    int src_idle [3] = '{10, 45, 0};
    int snk_idle [3] = '{45, 10, 0};

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Applies one request to the mirrored list and returns the response it should give
    function automatic mtf_rsp_t mtf_apply(input logic mode,
                                           input logic signed [mtf_pkg::VALUE_W-1:0] value);
        mtf_rsp_t r;
        int       hit;
        r.status = mtf_pkg::ST_APPENDED;
        r.pos    = '0;
        hit      = -1;
        if (mode == mtf_pkg::MODE_APPEND)
        begin
            if (list_len >= mtf_pkg::DEPTH)
                r.status = mtf_pkg::ST_FULL;
            else
            begin
                list_vals[list_len] = value;
                list_len++;
            end
        end
        else if (list_len == 0)
            r.status = mtf_pkg::ST_EMPTY;
        else
        begin
            for (int i = 0; i < list_len; i++)
                if (hit < 0 && list_vals[i] == value)
                    hit = i;
            if (hit < 0)
                r.status = mtf_pkg::ST_NOT_FOUND;
            else if (hit == 0)
                r.status = mtf_pkg::ST_AT_FRONT;
            else
            begin
                for (int i = hit; i > 0; i--)
                    list_vals[i] = list_vals[i-1];
                list_vals[0] = value;
                r.status = mtf_pkg::ST_MOVED;
                r.pos    = mtf_pkg::POS_W'(hit);
            end
        end
        r.count = mtf_pkg::COUNT_W'(list_len);
        return r;
    endfunction

    function automatic void push_req(input logic mode,
                                     input logic signed [mtf_pkg::VALUE_W-1:0] value);
        mtf_req_t it;
        it.mode  = mode;
        it.value = value;
        it.hold  = 1'b0;
        pending_q.push_back(it);
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        mtf_req_t nxt;
        logic     taken;
        int       outstanding;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.mode  <= mtf_pkg::MODE_APPEND;
            req_ch.value <= '0;
            phase        <= 0;
        end
        else
        begin
            taken = req_ch.valid && req_ch.ready;
            if (taken)
            begin
                outcome_q.push_back(mtf_apply(cur_req.mode, cur_req.value));
                req_taken++;
            end
            // rsp_seen is updated nonblocking, so count this edge's response transfer here
            outstanding = req_taken - rsp_seen - int'(rsp_ch.valid && rsp_ch.ready);
            phase <= (req_taken * 3 / total_items > 2) ? 2 : req_taken * 3 / total_items;
            if (!req_ch.valid || taken)
            begin
                if (pending_q.size() != 0 && !(pending_q[0].hold && outstanding != 0)
                    && $urandom_range(99) >= src_idle[phase])
                begin
                    nxt          = pending_q.pop_front();
                    cur_req      = nxt;
                    req_ch.valid <= 1'b1;
                    req_ch.mode  <= nxt.mode;
                    req_ch.value <= nxt.value;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        mtf_rsp_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen <= rsp_seen + 1;
                if (outcome_q.size() == 0)
                begin
                    $error("response with none outstanding: status %0d position %0d count %0d",
                           rsp_ch.status, rsp_ch.hit_position, rsp_ch.entry_count);
                    err_cnt++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        err_cnt++;
                    end
                    if (rsp_ch.hit_position !== want.pos)
                    begin
                        $error("hit_position: expected %0d, got %0d", want.pos,
                               rsp_ch.hit_position);
                        err_cnt++;
                    end
                    if (rsp_ch.entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count,
                               rsp_ch.entry_count);
                        err_cnt++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle[phase]);
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_MAX)
            begin
                $display("FAIL");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        val_pool[0] = 32'sh8000_0000;
        val_pool[1] = 32'sh7FFF_FFFF;
        val_pool[2] = 32'sh0000_0000;
        val_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++)
            val_pool[i] = $urandom;

        // Directed: empty list, single entry at front, extremes, duplicates, miss
        push_req(mtf_pkg::MODE_ACCESS, 32'sd5);
        push_req(mtf_pkg::MODE_APPEND, 32'sh8000_0000);
        push_req(mtf_pkg::MODE_ACCESS, 32'sh8000_0000);
        push_req(mtf_pkg::MODE_APPEND, 32'sh7FFF_FFFF);
        push_req(mtf_pkg::MODE_APPEND, 32'sh0000_0000);
        push_req(mtf_pkg::MODE_APPEND, -32'sd1);
        push_req(mtf_pkg::MODE_APPEND, 32'sh7FFF_FFFF);
        push_req(mtf_pkg::MODE_ACCESS, 32'sh7FFF_FFFF);
        push_req(mtf_pkg::MODE_ACCESS, 32'sh7FFF_FFFF);
        push_req(mtf_pkg::MODE_ACCESS, -32'sd1);
        push_req(mtf_pkg::MODE_ACCESS, 32'sd1);
        push_req(mtf_pkg::MODE_ACCESS, 32'sh0000_0000);
        push_req(mtf_pkg::MODE_ACCESS, 32'sh5555_5555);
        push_req(mtf_pkg::MODE_ACCESS, 32'shAAAA_AAAA);
        push_req(mtf_pkg::MODE_ACCESS, 32'sh8000_0000);

        // Random: mostly hits on a small pool; appends are rare so the list fills
        // gradually and then appends to a full list get dropped
        for (int n = 0; n < N_RANDOM; n++)
            push_req(($urandom_range(29) == 0) ? mtf_pkg::MODE_APPEND : mtf_pkg::MODE_ACCESS,
                     ($urandom_range(99) < 80) ? val_pool[$urandom_range(POOL_SIZE-1)]
                                               : $signed($urandom));

        total_items = pending_q.size();
        pending_q[15].hold              = 1'b1;
        pending_q[total_items / 3].hold = 1'b1;
        pending_q[2 * total_items / 3].hold = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_ch.valid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
